// ----- design/cpsd_pkg.sv -----
// shared types and constants for the charge plug signal debouncer
package cpsd_pkg;

    // widths fixed by the beat fields and registers
    localparam int unsigned VOLT_W  = 12;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned FLAG_W  = 8;
    localparam int unsigned CFG_W   = 12;

    // register reset values
    localparam logic [VOLT_W-1:0]  CC2_LOW_RST  = 12'd0;
    localparam logic [VOLT_W-1:0]  CC2_HIGH_RST = 12'd4095;
    localparam logic [MODE_W-1:0]  MODE_RST     = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 8'd100;

    // work mode codes
    localparam logic [MODE_W-1:0] MODE_DISCHARGE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLOW_CHG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FAST_CHG  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd3;

    // status flag bit positions
    localparam int unsigned F_DC       = 0;
    localparam int unsigned F_AC       = 1;
    localparam int unsigned F_KEY      = 2;
    localparam int unsigned F_CHGERR   = 3;
    localparam int unsigned F_RELAY    = 4;
    localparam int unsigned F_FASTEND  = 5;
    localparam int unsigned F_CONNFLT  = 6;
    localparam int unsigned F_CHARGING = 7;

    // configuration register index
    typedef enum logic [1:0] {
        CFG_CC2_LOW,
        CFG_CC2_HIGH,
        CFG_WORK_MODE,
        CFG_DEBOUNCE
    } t_cfg_idx;

    // input beat
    typedef struct packed {
        logic              boot_mode;
        logic              dc_gun_present;
        logic [VOLT_W-1:0] cc2_voltage;
        logic              ac_cc_present;
        logic              key_present;
        logic              charger_in_absent;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic dc_plug_connected;
        logic ac_plug_connected;
        logic key_on_confirmed;
        logic charger_in_error;
        logic relay_fault_poweroff;
        logic fast_charge_end;
        logic connector_fault;
        logic work_state_charging;
        logic main_power_off;
    } t_out_beat;

    // limit reached strobes from one counter pair
    typedef struct packed {
        logic on_hit;
        logic off_hit;
    } t_hits;

endpackage

// ----- design/cpsd_in_if.sv -----
// valid/ready channel carrying one sampled tick of connector inputs
interface cpsd_in_if;
    import cpsd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/cpsd_out_if.sv -----
// valid/ready channel carrying one qualified flag beat
interface cpsd_out_if;
    import cpsd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/cpsd_cnt_pair.sv -----
// on/off debounce counter pair for one connector input
module cpsd_cnt_pair
    import cpsd_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_level,
    input  logic [LIMIT_W-1:0] i_limit,
    input  logic               i_clr_on,
    output t_hits              o_hits
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [COUNT_WIDTH-1:0] r_on, r_off;
    logic [COUNT_WIDTH-1:0] n_on, n_off;
    logic [COUNT_WIDTH-1:0] on_inc, off_inc;
    logic                   on_reach, off_reach;

    // incremented counts wrap at the counter width
    assign on_inc    = r_on + 1'b1;
    assign off_inc   = r_off + 1'b1;
    assign on_reach  = CMP_W'(on_inc) >= CMP_W'(i_limit);
    assign off_reach = CMP_W'(off_inc) >= CMP_W'(i_limit);

    // hits only on a processed beat
    assign o_hits.on_hit  = i_step && i_level && on_reach;
    assign o_hits.off_hit = i_step && !i_level && off_reach;

    // next counts
    always_comb begin
        n_on  = r_on;
        n_off = r_off;
        if (i_step) begin
            if (i_level) begin
                n_off = '0;
                n_on  = (on_reach && i_clr_on) ? '0 : on_inc;
            end else begin
                n_on  = '0;
                n_off = off_reach ? '0 : off_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on  <= '0;
            r_off <= '0;
        end else begin
            r_on  <= n_on;
            r_off <= n_off;
        end
    end

endmodule

// ----- design/charge_plug_signal_debouncer.sv -----
// top level of the charge plug signal debouncer
// Qualifies one 5 ms tick sample of the DC gun, AC CC, key and charger-in
// inputs per beat through on/off counter pairs and sticky status flags, and
// returns one flag beat per input beat. A beat is captured in an input
// register, processed against the counters combinationally and placed in the
// result register, so one beat is taken every cycle while o_out.ready is high;
// the result then waits in the result register until o_out.ready takes it.
// The result register lets the next beat enter while a result waits.
// Configuration is written through a plain write port; the user writes it only while the block is idle, unenforced.
module charge_plug_signal_debouncer
    import cpsd_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cpsd_in_if.sink          i_in,
    cpsd_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic               r_in_valid;
    t_in_beat           r_in;
    logic               r_out_valid;
    t_out_beat          r_out;
    logic [FLAG_W-1:0]  r_flags;
    logic [FLAG_W-1:0]  n_flags;
    logic [VOLT_W-1:0]  r_cc2_low, r_cc2_high;
    logic [MODE_W-1:0]  r_mode;
    logic [LIMIT_W-1:0] r_limit;
    logic               advance;
    logic               win_ok;
    logic               en_dc, en_ac, en_key, en_chg;
    t_hits              dc_hits, ac_hits, key_hits, chg_hits;

    // pipeline handshake
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc2_low  <= CC2_LOW_RST;
            r_cc2_high <= CC2_HIGH_RST;
            r_mode     <= MODE_RST;
            r_limit    <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CC2_LOW:   r_cc2_low  <= i_cfg_wdata[VOLT_W-1:0];
                CFG_CC2_HIGH:  r_cc2_high <= i_cfg_wdata[VOLT_W-1:0];
                CFG_WORK_MODE: r_mode     <= i_cfg_wdata[MODE_W-1:0];
                CFG_DEBOUNCE:  r_limit    <= i_cfg_wdata[LIMIT_W-1:0];
                default:       r_limit    <= r_limit;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // counter gating: ac only without dc gun, key only without ac cc too
    assign en_dc  = advance && !r_in.boot_mode;
    assign en_ac  = en_dc && !r_in.dc_gun_present;
    assign en_key = en_ac && !r_in.ac_cc_present;
    assign en_chg = en_dc;

    // cc2 window check
    assign win_ok = (r_in.cc2_voltage <= r_cc2_high) && (r_in.cc2_voltage >= r_cc2_low);

    cpsd_cnt_pair #(.COUNT_WIDTH(COUNT_WIDTH)) u_dc_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (en_dc),
        .i_level (r_in.dc_gun_present),
        .i_limit (r_limit),
        .i_clr_on(win_ok),
        .o_hits  (dc_hits)
    );

    cpsd_cnt_pair #(.COUNT_WIDTH(COUNT_WIDTH)) u_ac_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (en_ac),
        .i_level (r_in.ac_cc_present),
        .i_limit (r_limit),
        .i_clr_on(1'b1),
        .o_hits  (ac_hits)
    );

    cpsd_cnt_pair #(.COUNT_WIDTH(COUNT_WIDTH)) u_key_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (en_key),
        .i_level (r_in.key_present),
        .i_limit (r_limit),
        .i_clr_on(1'b1),
        .o_hits  (key_hits)
    );

    // charger-in counts presence as the on side
    cpsd_cnt_pair #(.COUNT_WIDTH(COUNT_WIDTH)) u_chg_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (en_chg),
        .i_level (!r_in.charger_in_absent),
        .i_limit (r_limit),
        .i_clr_on(1'b1),
        .o_hits  (chg_hits)
    );

    // sticky flag update
    always_comb begin
        n_flags = r_flags;
        if (dc_hits.on_hit) begin
            if (win_ok) begin
                n_flags[F_DC]       = 1'b1;
                n_flags[F_CHARGING] = 1'b1;
            end else if (r_mode == MODE_DISCHARGE) begin
                n_flags[F_RELAY] = 1'b1;
                n_flags[F_DC]    = 1'b0;
            end else begin
                n_flags[F_FASTEND] = 1'b1;
                n_flags[F_CONNFLT] = 1'b1;
            end
        end
        if (dc_hits.off_hit) begin
            n_flags[F_DC] = 1'b0;
            if (r_mode == MODE_FAST_CHG) begin
                n_flags[F_FASTEND] = 1'b1;
                n_flags[F_CONNFLT] = 1'b1;
            end
        end
        if (ac_hits.on_hit) begin
            n_flags[F_AC] = 1'b1;
        end
        if (ac_hits.off_hit) begin
            n_flags[F_AC] = 1'b0;
        end
        if (key_hits.on_hit) begin
            n_flags[F_KEY] = 1'b1;
        end
        if (key_hits.off_hit) begin
            n_flags[F_KEY] = 1'b0;
        end
        if (chg_hits.off_hit) begin
            n_flags[F_CHGERR] = 1'b1;
        end
        if (chg_hits.on_hit) begin
            n_flags[F_CHGERR] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.dc_plug_connected    <= n_flags[F_DC];
            r_out.ac_plug_connected    <= n_flags[F_AC];
            r_out.key_on_confirmed     <= n_flags[F_KEY];
            r_out.charger_in_error     <= n_flags[F_CHGERR];
            r_out.relay_fault_poweroff <= n_flags[F_RELAY];
            r_out.fast_charge_end      <= n_flags[F_FASTEND];
            r_out.connector_fault      <= n_flags[F_CONNFLT];
            r_out.work_state_charging  <= n_flags[F_CHARGING];
            r_out.main_power_off       <= r_in.boot_mode;
        end
    end

    // boot beats leave the flags untouched
    a_boot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.boot_mode |=> r_flags == $past(r_flags))
        else $error("flags changed on a boot mode beat");

    // every processed beat yields a pending result
    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed beat produced no result");

    // result beat mirrors the flag state it was built from
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.dc_plug_connected == r_flags[F_DC])
            && (r_out.connector_fault == r_flags[F_CONNFLT])
            && (r_out.work_state_charging == r_flags[F_CHARGING]))
        else $error("result beat disagrees with flag state");

    // a stalled input register never drops its beat
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("input beat lost while stalled");

endmodule
